// ----- design/apts_pkg.sv -----
`timescale 1ns / 1ps
package apts_pkg;

	// Sizing of the scheduler
	localparam int LEVELS      = 10;
	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH   = 32;

	localparam int LVL_W       = $clog2(LEVELS);
	localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Fixed field widths on the ports
	localparam int PRIO_IN_W   = 5;
	localparam int TAG_IN_W    = 32;
	localparam int PRIO_OUT_W  = 4;
	localparam int TAG_OUT_W   = 32;
	localparam int STATUS_W    = 2;
	localparam int STAMP_W     = 32;
	localparam int THR_W       = 8;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 40;

	localparam logic [THR_W-1:0] AGING_RESET = THR_W'(5);

	localparam logic CMD_PUSH     = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED     = 2'd0,
		ST_DROPPED    = 2'd1,
		ST_DISPATCHED = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic scan;
		logic exec;
		logic load_out;
	} apts_cmd_t;

endpackage

// ----- design/apts_ram.sv -----
`timescale 1ns / 1ps
module apts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/apts_ctrl.sv -----
`timescale 1ns / 1ps
module apts_ctrl
	import apts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output apts_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EXEC = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d      = state_q;
		cmd.latch_in = 1'b0;
		cmd.scan     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/apts_dp.sv -----
`timescale 1ns / 1ps
module apts_dp
	import apts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  apts_cmd_t            cmd,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 cfg_wr_en,
	input  logic [THR_W-1:0]     cfg_wr_data,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]  m_tuser
);

	localparam int SUM_W = CNT_W + 1;

	// latched request
	logic                 cmd_q;
	logic [PRIO_IN_W-1:0] prio_raw_q;
	logic [TAG_WIDTH-1:0] tag_q;

	// per-level queue state
	logic [HEAD_W-1:0]    level_head_q  [LEVELS];
	logic [CNT_W-1:0]     level_count_q [LEVELS];
	logic [STAMP_W-1:0]   level_stamp_q [LEVELS];
	logic [STAMP_W-1:0]   disp_cnt_q;
	logic [THR_W-1:0]     thr_q;

	// scan results
	logic [LEVELS-1:0]    aged_q;
	logic [LEVELS-1:0]    nonempty_q;
	logic [LVL_W-1:0]     push_lvl_q;

	// pending result
	status_t              res_status_q;
	logic [PRIO_OUT_W-1:0] res_prio_q;
	logic                 res_tag_q;

	// output register
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]  m_tuser_q;

	logic [LVL_W-1:0]     clamp_lvl;
	logic [LVL_W-1:0]     sel_aged;
	logic [LVL_W-1:0]     sel_high;
	logic                 any_aged;
	logic [LVL_W-1:0]     disp_lvl;
	logic                 push_full;
	logic [SUM_W-1:0]     slot_sum;
	logic [HEAD_W-1:0]    push_slot;
	logic [HEAD_W-1:0]    pop_head;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic                 ram_we;
	logic                 ram_re;
	logic [TAG_WIDTH-1:0] rd_data;
	logic [63:0]          tag_in_wide;
	logic [63:0]          rd_wide;

	assign tag_in_wide = 64'(s_tdata[PRIO_IN_W +: TAG_IN_W]);
	assign rd_wide     = 64'(rd_data);

	// clamp the signed priority into the level range
	always_comb begin
		if (prio_raw_q[PRIO_IN_W-1]) begin
			clamp_lvl = '0;
		end else if (int'(prio_raw_q[PRIO_IN_W-2:0]) >= LEVELS) begin
			clamp_lvl = LVL_W'(LEVELS - 1);
		end else begin
			clamp_lvl = LVL_W'(prio_raw_q[PRIO_IN_W-2:0]);
		end
	end

	// lowest aged level, highest non-empty level
	always_comb begin
		sel_aged = '0;
		sel_high = '0;
		any_aged = |aged_q;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (aged_q[i]) begin
				sel_aged = LVL_W'(i);
			end
		end
		for (int i = 0; i < LEVELS; i++) begin
			if (nonempty_q[i]) begin
				sel_high = LVL_W'(i);
			end
		end
	end

	assign disp_lvl  = any_aged ? sel_aged : sel_high;
	assign push_full = (int'(level_count_q[push_lvl_q]) == QUEUE_DEPTH);
	assign slot_sum  = SUM_W'(level_head_q[push_lvl_q]) + SUM_W'(level_count_q[push_lvl_q]);
	assign push_slot = (int'(slot_sum) >= QUEUE_DEPTH) ? HEAD_W'(int'(slot_sum) - QUEUE_DEPTH)
	                                                   : HEAD_W'(slot_sum);
	assign pop_head  = level_head_q[disp_lvl];

	assign waddr  = ADDR_W'(int'(push_lvl_q) * QUEUE_DEPTH) + ADDR_W'(push_slot);
	assign raddr  = ADDR_W'(int'(disp_lvl) * QUEUE_DEPTH) + ADDR_W'(pop_head);
	assign ram_we = cmd.exec && (cmd_q == CMD_PUSH) && !push_full;
	assign ram_re = cmd.exec && (cmd_q == CMD_DISPATCH) && (|nonempty_q);

	apts_ram #(
		.WIDTH(TAG_WIDTH),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(tag_q),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q      <= s_tuser;
			prio_raw_q <= s_tdata[PRIO_IN_W-1:0];
			tag_q      <= tag_in_wide[TAG_WIDTH-1:0];
		end
		if (cmd.scan) begin
			push_lvl_q <= clamp_lvl;
			for (int i = 0; i < LEVELS; i++) begin
				nonempty_q[i] <= (level_count_q[i] != '0);
				aged_q[i]     <= (level_count_q[i] != '0) &&
				                 ((disp_cnt_q - level_stamp_q[i]) >= STAMP_W'(thr_q));
			end
		end
		if (cmd.exec) begin
			if (cmd_q == CMD_PUSH) begin
				res_status_q <= push_full ? ST_DROPPED : ST_PUSHED;
				res_prio_q   <= PRIO_OUT_W'(push_lvl_q);
				res_tag_q    <= 1'b0;
			end else if (|nonempty_q) begin
				res_status_q <= ST_DISPATCHED;
				res_prio_q   <= PRIO_OUT_W'(disp_lvl);
				res_tag_q    <= 1'b1;
			end else begin
				res_status_q <= ST_EMPTY;
				res_prio_q   <= '0;
				res_tag_q    <= 1'b0;
			end
		end
		if (cmd.load_out) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= M_TDATA_W'({(res_tag_q ? rd_wide[TAG_OUT_W-1:0] : TAG_OUT_W'(0)),
			                         res_prio_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				level_head_q[i]  <= '0;
				level_count_q[i] <= '0;
				level_stamp_q[i] <= '0;
			end
			disp_cnt_q <= '0;
			thr_q      <= AGING_RESET;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (ram_we) begin
				level_count_q[push_lvl_q] <= level_count_q[push_lvl_q] + CNT_W'(1);
			end
			if (ram_re) begin
				level_head_q[disp_lvl]  <= (int'(pop_head) == QUEUE_DEPTH - 1) ? '0
				                                                            : pop_head + HEAD_W'(1);
				level_count_q[disp_lvl] <= level_count_q[disp_lvl] - CNT_W'(1);
				level_stamp_q[disp_lvl] <= disp_cnt_q;
				disp_cnt_q              <= disp_cnt_q + STAMP_W'(1);
			end
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// ----- design/aged_priority_task_scheduler.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)                       tuser
// s_        in         [4:0] requested_priority, [36:5] task_tag  [0] cmd
// m_        out        [3:0] served_priority, [35:4] served_tag   [1:0] status
// cfg_      in         cfg_wr_data = aging_threshold            -
//
// Each request passes through four steps: accept, level scan
// (aged and non-empty flags registered), execute (one task store access and the
// queue state update), and result load once the output is free. The store's registered read sets the
// last step. A result waiting on m_tready holds the sequencer in its result step;
// the next request is accepted while a finished result sits in the output register.
// Reset clears queue heads, counts, stamps, the dispatch counter and sets the
// aging threshold to 5; the task store is not cleared.
module aged_priority_task_scheduler
	import apts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [4:0] requested_priority, [36:5] task_tag
	input  logic                 s_tuser,  // [0] cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [3:0] served_priority, [35:4] served_tag
	output logic [STATUS_W-1:0]  m_tuser,  // [1:0] status
	input  logic                 cfg_wr_en,
	input  logic [THR_W-1:0]     cfg_wr_data
);

	apts_cmd_t cmd;

	// Sequencer: advance one request through scan, execute and result load
	apts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	// Datapath: level queues, aging stamps, task store and output register
	apts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ----- tb/sched_result_checker.sv -----
`timescale 1ns / 1ps
module sched_result_checker
	import apts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [4:0] requested_priority, [36:5] task_tag
	input  logic                 s_tuser,  // [0] cmd
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,  // [3:0] served_priority, [35:4] served_tag
	input  logic [STATUS_W-1:0]  m_tuser,  // [1:0] status
	input  logic                 cfg_wr_en,
	input  logic [THR_W-1:0]     cfg_wr_data,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		status_t                status;
		logic [PRIO_OUT_W-1:0]  level;
		logic [TAG_OUT_W-1:0]   tag;
	} sched_result_t;

	sched_result_t pending_results[$];
	sched_result_t got;
	sched_result_t want;

	// Shadow copy of the scheduler queues
	logic [TAG_WIDTH-1:0] tag_mem [LEVELS][QUEUE_DEPTH];
	logic [HEAD_W-1:0]    q_head [LEVELS];
	logic [CNT_W-1:0]     q_count [LEVELS];
	logic [STAMP_W-1:0]   served_stamp [LEVELS];
	logic [STAMP_W-1:0]   dispatch_count;
	logic [THR_W-1:0]     aging_thr;

	function automatic logic [LVL_W-1:0] clamp_level(input logic [PRIO_IN_W-1:0] raw);
		if (raw[PRIO_IN_W-1])
			return '0;
		if (raw >= LEVELS)
			return LVL_W'(LEVELS - 1);
		return raw[LVL_W-1:0];
	endfunction

	task automatic schedule_request(input logic cmd, input logic [PRIO_IN_W-1:0] raw,
			input logic [TAG_IN_W-1:0] tag, output sched_result_t res);
		logic [LVL_W-1:0]   lvl;
		logic [STAMP_W-1:0] lag;
		logic               found;
		int                 slot;
		int                 i;
		res.status = ST_EMPTY;
		res.level  = '0;
		res.tag    = '0;
		if (cmd == CMD_PUSH) begin
			lvl       = clamp_level(raw);
			res.level = lvl;
			if (q_count[lvl] >= QUEUE_DEPTH) begin
				res.status = ST_DROPPED;
			end else begin
				slot                = (q_head[lvl] + q_count[lvl]) % QUEUE_DEPTH;
				tag_mem[lvl][slot]  = tag;
				q_count[lvl]        = q_count[lvl] + 1'b1;
				res.status          = ST_PUSHED;
			end
		end else begin
			found = 1'b0;
			lvl   = '0;
			// aged levels first, lowest level wins
			for (i = 0; i < LEVELS && !found; i++) begin
				lag = dispatch_count - served_stamp[i];
				if (q_count[i] != 0 && lag >= aging_thr) begin
					lvl   = LVL_W'(i);
					found = 1'b1;
				end
			end
			// then plain priority, highest level wins
			for (i = LEVELS - 1; i >= 0 && !found; i--) begin
				if (q_count[i] != 0) begin
					lvl   = LVL_W'(i);
					found = 1'b1;
				end
			end
			if (found) begin
				res.status        = ST_DISPATCHED;
				res.level         = lvl;
				res.tag           = tag_mem[lvl][q_head[lvl]];
				q_head[lvl]       = HEAD_W'((q_head[lvl] + 1) % QUEUE_DEPTH);
				q_count[lvl]      = q_count[lvl] - 1'b1;
				served_stamp[lvl] = dispatch_count;
				dispatch_count    = dispatch_count + 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LEVELS; k++) begin
				q_head[k]       = '0;
				q_count[k]      = '0;
				served_stamp[k] = '0;
			end
			dispatch_count = '0;
			aging_thr      = AGING_RESET;
			pending_results.delete();
			outstanding    = 0;
			mismatches     = 0;
		end else begin
			// retire results before predicting new requests
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.level  = m_tdata[PRIO_OUT_W-1:0];
				got.tag    = m_tdata[PRIO_OUT_W +: TAG_OUT_W];
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d level %0d tag %h",
						$time, got.status, got.level, got.tag);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					outstanding--;
					if (got.status != want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						mismatches++;
					end
					if (got.level != want.level) begin
						$display("%0t: served_priority expected %0d actual %0d",
							$time, want.level, got.level);
						mismatches++;
					end
					if (got.tag != want.tag) begin
						$display("%0t: served_tag expected %h actual %h",
							$time, want.tag, got.tag);
						mismatches++;
					end
				end
			end
			if (cfg_wr_en)
				aging_thr = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				schedule_request(s_tuser, s_tdata[PRIO_IN_W-1:0],
					s_tdata[PRIO_IN_W +: TAG_IN_W], want);
				pending_results = {pending_results, want};
				outstanding++;
			end
		end
	end

endmodule

// ----- tb/tb_aged_priority_task_scheduler.sv -----
`timescale 1ns / 1ps
module tb_aged_priority_task_scheduler;
	import apts_pkg::*;

	localparam int CYCLE_LIMIT      = 300000;
	localparam int RANDOM_PER_PHASE = 175;
	localparam int PHASES           = 5;
	localparam int HOLD_CYCLES      = 300;
	localparam int DRAIN_CYCLES     = 20;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [4:0] requested_priority, [36:5] task_tag
	logic                 s_tuser;   // [0] cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;   // [3:0] served_priority, [35:4] served_tag
	logic [STATUS_W-1:0]  m_tuser;   // [1:0] status
	logic                 cfg_wr_en;
	logic [THR_W-1:0]     cfg_wr_data;

	int mismatches;
	int outstanding;
	int cycle_count = 0;

	// Idle percentages for the request and result sides
	int tx_idle_pct = 19;
	int rx_idle_pct = 79;

	// Long receiver stall: bump hold_req, the receiver process does the counting
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int thr_plan  [PHASES] = '{0, 255, 1, 0, 5};
	int push_plan [PHASES] = '{55, 70, 45, 60, 50};

	aged_priority_task_scheduler i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	sched_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_aged_priority_task_scheduler NOT OK");
			$finish;
		end
	end

	// Result side: random back-pressure, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one request and hold it until the block takes it. Enter and leave
	// at a falling edge; tvalid stays high when the next request follows at once.
	task automatic send_request(input logic cmd, input logic [PRIO_IN_W-1:0] prio,
			input logic [TAG_IN_W-1:0] tag);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(S_TDATA_W - PRIO_IN_W - TAG_IN_W){1'b0}}, tag, prio};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Mostly legal levels with one hot level to fill, some raw 5-bit values
	task automatic send_random(input int push_pct, input int hot);
		logic [PRIO_IN_W-1:0] prio;
		logic                 cmd;
		int                   pick;
		pick = $urandom_range(99);
		if (pick < 50)
			prio = PRIO_IN_W'($urandom_range(0, LEVELS - 1));
		else if (pick < 80)
			prio = PRIO_IN_W'(hot);
		else
			prio = PRIO_IN_W'($urandom_range(0, 31));
		cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_DISPATCH;
		send_request(cmd, prio, $urandom());
	endtask

	// Drop tvalid and hold until every expected result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int hot;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = CMD_PUSH;
		s_tdata     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		thr_plan[3] = $urandom_range(2, 254);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset threshold in effect.
		// Dispatch with nothing waiting; payload fields must be ignored.
		send_request(CMD_DISPATCH, 5'h1F, 32'hFFFF_FFFF);
		// Most negative and minus one clamp to level 0; tag extremes.
		send_request(CMD_PUSH, 5'h10, 32'h0000_0000);
		send_request(CMD_PUSH, 5'h1F, 32'hFFFF_FFFF);
		// Top level itself and values above it clamp to the top level.
		send_request(CMD_PUSH, 5'd15, 32'hA5A5_5A5A);
		send_request(CMD_PUSH, 5'd10, 32'h0000_0001);
		send_request(CMD_PUSH, 5'd9, 32'h8000_0000);
		// Fill level 3 and push once more to force a drop on a full queue.
		for (int n = 0; n <= QUEUE_DEPTH; n++)
			send_request(CMD_PUSH, 5'd3, 32'h3000_0000 + n);
		// No level has aged yet: serve the top level, and again the top level.
		send_request(CMD_DISPATCH, 5'd0, 32'h0);
		send_request(CMD_DISPATCH, 5'd0, 32'h0);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= THR_W'(thr_plan[ph]);
			@(negedge clk);
			cfg_wr_en   <= 1'b0;
			tx_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 79 : 0;
			rx_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 19 : 0;
			hot         = $urandom_range(0, LEVELS - 1);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Stall the result side while requests keep coming
				if (ph == PHASES - 1 && n == 20)
					hold_req++;
				// Move the hot level now and then so several queues fill
				if (n % 60 == 59)
					hot = $urandom_range(0, LEVELS - 1);
				send_random(push_plan[ph], hot);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_aged_priority_task_scheduler OK");
		else
			$display("tb_aged_priority_task_scheduler NOT OK");
		$finish;
	end

endmodule

// ----- aged_priority_task_scheduler.f -----
design/apts_pkg.sv
design/apts_ram.sv
design/apts_ctrl.sv
design/apts_dp.sv
design/aged_priority_task_scheduler.sv
tb/sched_result_checker.sv
tb/tb_aged_priority_task_scheduler.sv
